// ===== hw/rtl/lsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lsf_pkg - LED smoothstep fade package
// Shared widths, request codes, event codes and register indexes.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int unsigned FRAC    = 12;
  localparam int unsigned LVL_W   = FRAC + 1;
  localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1) << FRAC;

  localparam int unsigned MUL_A_W = 2 * LVL_W;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_FADE   = 2'd1,
    REQ_STOP   = 2'd2,
    REQ_TOGGLE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_ON   = 2'd1,
    EV_OFF  = 2'd2
  } event_t;

  localparam logic [1:0] CFG_PERIOD    = 2'd0;
  localparam logic [1:0] CFG_INVERTED  = 2'd1;
  localparam logic [1:0] CFG_ACTIVE    = 2'd2;
  localparam logic [1:0] CFG_COMPOSITE = 2'd3;

  typedef struct packed {
    logic start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

// ===== hw/rtl/lsf_div.sv =====
// ----------------------------------------------------------------------------
// lsf_div - fade position divider
// Restoring divider, one quotient bit per cycle: floor(step * 2^FRAC / steps)
// for step below steps.
// ----------------------------------------------------------------------------
module lsf_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [15:0]              step,
  input  logic [15:0]              steps,
  output logic                     done,
  output logic [lsf_pkg::FRAC-1:0] quot
);

  logic [16:0]              rem_r, rem_nxt;
  logic [15:0]              den_r;
  logic [lsf_pkg::FRAC-1:0] quot_r, quot_nxt;
  logic [3:0]               cnt_r;
  logic                     run_r, done_r;
  logic [16:0]              trial;

  assign trial = {rem_r[15:0], 1'b0};

  always_comb begin
    if (trial >= {1'b0, den_r}) begin
      rem_nxt  = trial - {1'b0, den_r};
      quot_nxt = {quot_r[lsf_pkg::FRAC-2:0], 1'b1};
    end else begin
      rem_nxt  = trial;
      quot_nxt = {quot_r[lsf_pkg::FRAC-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= {1'b0, step};
        den_r  <= steps;
        quot_r <= '0;
        cnt_r  <= '0;
        run_r  <= 1'b1;
      end else if (run_r) begin
        rem_r  <= rem_nxt;
        quot_r <= quot_nxt;
        cnt_r  <= cnt_r + 4'd1;
        if (cnt_r == 4'(lsf_pkg::FRAC - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== hw/rtl/lsf_mul.sv =====
// ----------------------------------------------------------------------------
// lsf_mul - serial multiplier
// Shift-add multiplier, one multiplier bit per cycle, shared by every
// product of the fade and duty path.
// ----------------------------------------------------------------------------
module lsf_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lsf_pkg::mul_req_t           req,
  output logic                        done,
  output logic [lsf_pkg::MUL_P_W-1:0] prod
);

  logic [lsf_pkg::MUL_P_W-1:0] a_r, acc_r;
  logic [lsf_pkg::MUL_B_W-1:0] b_r;
  logic [4:0]                  cnt_r;
  logic                        run_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r   <= lsf_pkg::MUL_P_W'(req.a);
        b_r   <= req.b;
        acc_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (b_r[0]) begin
          acc_r <= acc_r + a_r;
        end
        a_r   <= {a_r[lsf_pkg::MUL_P_W-2:0], 1'b0};
        b_r   <= {1'b0, b_r[lsf_pkg::MUL_B_W-1:1]};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(lsf_pkg::MUL_B_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== hw/rtl/led_smoothstep_fade_pwm_unit.sv =====
// ----------------------------------------------------------------------------
// led_smoothstep_fade_pwm_unit - LED fade engine with smoothstep easing
// Fade, stop and toggle requests per channel; each tick advances every active
// fading channel and emits its square-law PWM duty and on/off event.
//
//   channel  ports                                   handshake
//   input    in_req_type in_channel in_target_level  start / busy
//            in_fade_steps
//   result   out_channel out_duty out_switch_event   out_valid, one cycle
//            out_last
//   config   cfg_index cfg_data                      cfg_we
//
// Fade, stop and toggle finish in the accepting cycle. A tick scans the active
// channels from the accepting cycle to a closing scan, skipping those that are
// not fading; each fading channel takes a position divide when its position
// needs it, then five passes through the one shared serial multiplier.
// Reset is synchronous and clears all channel state. Results cannot be
// stalled; busy holds off new items until the tick is done.
// ----------------------------------------------------------------------------
module led_smoothstep_fade_pwm_unit #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [2:0]  in_channel,
  input  logic [12:0] in_target_level,
  input  logic [15:0] in_fade_steps,
  output logic        out_valid,
  output logic [2:0]  out_channel,
  output logic [15:0] out_duty,
  output logic [1:0]  out_switch_event,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned LW = lsf_pkg::LVL_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DIV, S_MTT, S_MS, S_MLV, S_MSQ, S_MQ
  } state_t;

  state_t state_r;

  logic [15:0] period_r;
  logic        inverted_r, composite_r;
  logic [3:0]  active_r;

  logic [LW-1:0] cur_r    [CHANNELS];
  logic [LW-1:0] from_r   [CHANNELS];
  logic [LW-1:0] goal_r   [CHANNELS];
  logic [LW-1:0] preset_r [CHANNELS];
  logic [15:0]   stepc_r  [CHANNELS];
  logic [15:0]   total_r  [CHANNELS];
  logic [CHANNELS-1:0] fading_r;

  logic [3:0]    ch_r;
  logic [LW-1:0] t_r, lv_r;
  logic          old_zero_r;

  logic        out_valid_r, out_last_r;
  logic [2:0]  out_channel_r;
  logic [15:0] out_duty_r;
  logic [1:0]  out_event_r;

  logic [CW-1:0]  idx;
  logic [3:0]     n_act;
  logic [7:0]     lit8, fad8;
  logic [LW-1:0]  tgt_sat;
  logic [15:0]    step_new;
  logic [LW-1:0]  from_c, goal_c, diff, m, lv_c;
  logic           rising;
  logic [15:0]    q;
  logic [16:0]    dfull;
  logic [15:0]    duty_c;
  logic [2:0]     partner;
  logic [1:0]     ev_c;
  logic           last_c;

  lsf_pkg::mul_req_t                mreq;
  logic                             mdone, ddone, dstart;
  logic [lsf_pkg::MUL_P_W-1:0]      prod;
  logic [lsf_pkg::FRAC-1:0]         quot;

  lsf_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(dstart),
    .step (step_new),
    .steps(total_r[idx]),
    .done (ddone),
    .quot (quot)
  );

  lsf_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .done (mdone),
    .prod (prod)
  );

  assign idx      = (state_r == S_IDLE) ? in_channel[CW-1:0] : ch_r[CW-1:0];
  assign n_act    = (active_r > 4'(CHANNELS)) ? 4'(CHANNELS) : active_r;
  assign tgt_sat  = (in_target_level > lsf_pkg::LVL_ONE) ? lsf_pkg::LVL_ONE
                                                         : in_target_level;
  assign step_new = stepc_r[idx] + 16'd1;
  assign from_c   = from_r[idx];
  assign goal_c   = goal_r[idx];
  assign rising   = goal_c >= from_c;
  assign diff     = rising ? goal_c - from_c : from_c - goal_c;
  assign m        = prod[lsf_pkg::FRAC +: LW];
  assign lv_c     = rising ? from_c + m : from_c - m;
  assign q        = prod[2*lsf_pkg::FRAC +: 16];
  assign dfull    = (q == 16'd0) ? {1'b0, period_r} + 17'd1
                                 : {1'b0, period_r} - {1'b0, q};
  assign duty_c   = inverted_r ? q : (dfull[16] ? 16'hFFFF : dfull[15:0]);
  assign partner  = {ch_r[2:1], ~ch_r[0]};

  always_comb begin
    lit8 = '0;
    fad8 = '0;
    for (int j = 0; j < CHANNELS; j++) begin
      lit8[j] = (cur_r[j] != '0);
      fad8[j] = fading_r[j];
    end
  end

  always_comb begin
    last_c = 1'b1;
    for (int j = 0; j < 8; j++) begin
      if (4'(j) > ch_r && 4'(j) < n_act && fad8[j]) begin
        last_c = 1'b0;
      end
    end
  end

  always_comb begin
    ev_c = lsf_pkg::EV_NONE;
    if (old_zero_r || lv_r == '0) begin
      ev_c = (lv_r == '0) ? lsf_pkg::EV_OFF : lsf_pkg::EV_ON;
      // in composite mode, hold the off event while the partner channel is still lit
      if (lv_r == '0 && composite_r && lit8[partner]) begin
        ev_c = lsf_pkg::EV_NONE;
      end
    end
  end

  always_comb begin
    mreq   = '0;
    dstart = 1'b0;
    unique case (state_r)
      S_SCAN: begin
        if (ch_r < n_act && fading_r[idx] && total_r[idx] != 16'd0 &&
            step_new < total_r[idx]) begin
          dstart = 1'b1;
        end else if (ch_r < n_act && fading_r[idx]) begin
          mreq.start = 1'b1;
          mreq.a     = lsf_pkg::MUL_A_W'(lsf_pkg::LVL_ONE);
          mreq.b     = lsf_pkg::MUL_B_W'(lsf_pkg::LVL_ONE);
        end
      end
      S_DIV: begin
        mreq.start = ddone;
        mreq.a     = lsf_pkg::MUL_A_W'(quot);
        mreq.b     = lsf_pkg::MUL_B_W'(quot);
      end
      S_MTT: begin
        mreq.start = mdone;
        mreq.a     = prod[lsf_pkg::MUL_A_W-1:0];
        mreq.b     = lsf_pkg::MUL_B_W'(3 * lsf_pkg::LVL_ONE) -
                     lsf_pkg::MUL_B_W'({t_r, 1'b0});
      end
      S_MS: begin
        mreq.start = mdone;
        mreq.a     = lsf_pkg::MUL_A_W'(prod[2*lsf_pkg::FRAC +: LW]);
        mreq.b     = lsf_pkg::MUL_B_W'(diff);
      end
      S_MLV: begin
        mreq.start = mdone;
        mreq.a     = lsf_pkg::MUL_A_W'(lv_c);
        mreq.b     = lsf_pkg::MUL_B_W'(lv_c);
      end
      S_MSQ: begin
        mreq.start = mdone;
        mreq.a     = prod[lsf_pkg::MUL_A_W-1:0];
        mreq.b     = period_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= 16'd1200;
      inverted_r  <= 1'b0;
      active_r    <= 4'd2;
      composite_r <= 1'b0;
      fading_r    <= '0;
      out_valid_r <= 1'b0;
      ch_r        <= '0;
      for (int j = 0; j < CHANNELS; j++) begin
        cur_r[j]    <= '0;
        from_r[j]   <= '0;
        goal_r[j]   <= '0;
        preset_r[j] <= '0;
        stepc_r[j]  <= '0;
        total_r[j]  <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          lsf_pkg::CFG_PERIOD:    period_r    <= cfg_data;
          lsf_pkg::CFG_INVERTED:  inverted_r  <= cfg_data[0];
          lsf_pkg::CFG_ACTIVE:    active_r    <= cfg_data[3:0];
          lsf_pkg::CFG_COMPOSITE: composite_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_req_type == lsf_pkg::REQ_TICK) begin
              ch_r    <= '0;
              state_r <= S_SCAN;
            end else if ({1'b0, in_channel} < 4'(CHANNELS)) begin
              case (in_req_type)
                lsf_pkg::REQ_STOP: begin
                  fading_r[idx] <= 1'b0;
                  total_r[idx]  <= '0;
                  stepc_r[idx]  <= '0;
                end
                lsf_pkg::REQ_FADE, lsf_pkg::REQ_TOGGLE: begin
                  from_r[idx]   <= cur_r[idx];
                  fading_r[idx] <= 1'b1;
                  total_r[idx]  <= in_fade_steps;
                  stepc_r[idx]  <= '0;
                  if (in_req_type == lsf_pkg::REQ_FADE) begin
                    goal_r[idx] <= tgt_sat;
                  end else if (cur_r[idx] == '0) begin
                    goal_r[idx] <= preset_r[idx];
                  end else begin
                    preset_r[idx] <= cur_r[idx];
                    goal_r[idx]   <= '0;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        S_SCAN: begin
          if (ch_r >= n_act) begin
            state_r <= S_IDLE;
          end else if (!fading_r[idx]) begin
            ch_r <= ch_r + 4'd1;
          end else begin
            stepc_r[idx] <= step_new;
            old_zero_r   <= (cur_r[idx] == '0);
            t_r          <= lsf_pkg::LVL_ONE;
            state_r      <= dstart ? S_DIV : S_MTT;
          end
        end
        S_DIV: begin
          if (ddone) begin
            t_r     <= LW'(quot);
            state_r <= S_MTT;
          end
        end
        S_MTT: if (mdone) state_r <= S_MS;
        S_MS:  if (mdone) state_r <= S_MLV;
        S_MLV: begin
          if (mdone) begin
            lv_r       <= lv_c;
            cur_r[idx] <= lv_c;
            state_r    <= S_MSQ;
          end
        end
        S_MSQ: if (mdone) state_r <= S_MQ;
        S_MQ: begin
          if (mdone) begin
            out_valid_r   <= 1'b1;
            out_channel_r <= ch_r[2:0];
            out_duty_r    <= duty_c;
            out_event_r   <= ev_c;
            out_last_r    <= last_c;
            if (stepc_r[idx] >= total_r[idx]) begin
              fading_r[idx] <= 1'b0;
            end
            ch_r    <= ch_r + 4'd1;
            state_r <= S_SCAN;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_duty         = out_duty_r;
  assign out_switch_event = out_event_r;
  assign out_last         = out_last_r;

endmodule

// ===== hw/rtl/lsf_checker.sv =====
// ----------------------------------------------------------------------------
// lsf_checker - port-level checks for the fade unit
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module lsf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_req_type,
  input logic       out_valid,
  input logic [1:0] out_switch_event
);

  a_out_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a tick");

  a_req_instant: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type != lsf_pkg::REQ_TICK |=> !busy)
    else $error("request did not finish at once");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("results back to back");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid) else $error("reset left unit active");

  a_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_switch_event != 2'd3) else $error("bad event code");

endmodule

bind led_smoothstep_fade_pwm_unit lsf_checker u_lsf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_req_type     (in_req_type),
  .out_valid       (out_valid),
  .out_switch_event(out_switch_event)
);
